FILE: src/owtr_pkg.sv
// owtr_pkg: shared types and constants of the single-wire temperature reader
// phase codes, command bytes, register indexes, config and result structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package owtr_pkg;

    // register index port width and register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_RESET_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRES_TMO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVERY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PRE_READ   = 3'd5;

    // register reset values
    localparam logic [9:0]  RST_RESET_HIGH = 10'd260;
    localparam logic [10:0] RST_RESET_LOW  = 11'd750;
    localparam logic [16:0] RST_PRES_TMO   = 17'd80000;
    localparam logic [9:0]  RST_RECOVERY   = 10'd100;
    localparam logic [7:0]  RST_SLOT       = 8'd60;
    localparam logic [7:0]  RST_PRE_READ   = 8'd10;

    // bus command bytes
    localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
    localparam logic [7:0] CMD_CONVERT   = 8'h44;
    localparam logic [7:0] CMD_READ_SCR  = 8'hBE;

    // sequence steps
    localparam logic [2:0] STEP_SKIP_A   = 3'd0;
    localparam logic [2:0] STEP_CONVERT  = 3'd1;
    localparam logic [2:0] STEP_RESET_B  = 3'd2;
    localparam logic [2:0] STEP_SKIP_B   = 3'd3;
    localparam logic [2:0] STEP_READ_CMD = 3'd4;
    localparam logic [2:0] STEP_RD_LOW   = 3'd5;
    localparam logic [2:0] STEP_RD_HIGH  = 3'd6;

    localparam logic [2:0] LAST_BIT = 3'd7;

    // stream widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;
    localparam int RES_W     = 20;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_HIGH = 4'd1,
        PH_RST_LOW  = 4'd2,
        PH_PRESENCE = 4'd3,
        PH_RECOVERY = 4'd4,
        PH_WR_LOW   = 4'd5,
        PH_WR_HIGH  = 4'd6,
        PH_RD_PRE   = 4'd7,
        PH_RD_LOW   = 4'd8,
        PH_RD_GAP   = 4'd9,
        PH_RD_WAIT  = 4'd10
    } phase_t;

    typedef struct packed {
        logic [9:0]  reset_high_ticks;
        logic [10:0] reset_low_ticks;
        logic [16:0] presence_timeout_ticks;
        logic [9:0]  recovery_ticks;
        logic [7:0]  slot_ticks;
        logic [7:0]  pre_read_ticks;
    } owtr_cfg_t;

    // result item, lowest bit first: drive_low, busy_res, done_res,
    // raw_reading, presence_missing
    typedef struct packed {
        logic               presence_missing;
        logic signed [15:0] raw_reading;
        logic               done_res;
        logic               busy_res;
        logic               drive_low;
    } owtr_res_t;

endpackage

`default_nettype wire

FILE: src/owtr_cfg_regs.sv
// owtr_cfg_regs: timing register file written through the config channel
// depends on owtr_pkg
`timescale 1ns / 1ps
`default_nettype none

module owtr_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [owtr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [owtr_pkg::CFG_DATA_W-1:0] cfg_data,
    output owtr_pkg::owtr_cfg_t                 cfg
);
    import owtr_pkg::*;

    owtr_cfg_t cfg_reg;
    owtr_cfg_t cfg_next;

    // registers are always writable
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // decode one write transfer
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_RESET_HIGH: cfg_next.reset_high_ticks       = cfg_data[9:0];
                REG_RESET_LOW:  cfg_next.reset_low_ticks        = cfg_data[10:0];
                REG_PRES_TMO:   cfg_next.presence_timeout_ticks = cfg_data[16:0];
                REG_RECOVERY:   cfg_next.recovery_ticks         = cfg_data[9:0];
                REG_SLOT:       cfg_next.slot_ticks             = cfg_data[7:0];
                REG_PRE_READ:   cfg_next.pre_read_ticks         = cfg_data[7:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_high_ticks       <= RST_RESET_HIGH;
            cfg_reg.reset_low_ticks        <= RST_RESET_LOW;
            cfg_reg.presence_timeout_ticks <= RST_PRES_TMO;
            cfg_reg.recovery_ticks         <= RST_RECOVERY;
            cfg_reg.slot_ticks             <= RST_SLOT;
            cfg_reg.pre_read_ticks         <= RST_PRE_READ;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/owtr_seq.sv
// owtr_seq: bus sequencer state and one-tick next-state logic
// advances one tick per enabled cycle and gives that tick's result
// depends on owtr_pkg
`timescale 1ns / 1ps
`default_nettype none

module owtr_seq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                tick_en,
    input  wire logic                start_req,
    input  wire logic                line_in,
    input  wire owtr_pkg::owtr_cfg_t cfg,
    output owtr_pkg::owtr_res_t      res
);
    import owtr_pkg::*;

    phase_t      phase_reg,   phase_next;
    logic [16:0] tick_reg,    tick_next;
    logic [2:0]  bit_reg,     bit_next;
    logic [2:0]  step_reg,    step_next;
    logic [7:0]  shift_reg,   shift_next;
    logic [15:0] reading_reg, reading_next;
    logic        presence_reg, presence_next;
    logic [7:0]  low_byte_reg, low_byte_next;

    logic [16:0] tick_inc;
    logic [16:0] dur_sel;
    logic        hit;
    logic        begin_step;
    logic [2:0]  begin_idx;
    logic [7:0]  rd_shift;
    logic        drive;
    logic        busy;
    logic        done;

    // timed phase length for the current phase
    always_comb
    begin
        unique case (phase_reg)
            PH_RST_HIGH: dur_sel = 17'(cfg.reset_high_ticks);
            PH_RST_LOW:  dur_sel = 17'(cfg.reset_low_ticks);
            PH_RECOVERY: dur_sel = 17'(cfg.recovery_ticks);
            PH_WR_LOW:   dur_sel = shift_reg[0] ? 17'd1 : 17'(cfg.slot_ticks);
            PH_WR_HIGH:  dur_sel = shift_reg[0] ? 17'(cfg.slot_ticks) : 17'd1;
            PH_RD_PRE:   dur_sel = 17'(cfg.pre_read_ticks);
            PH_RD_WAIT:  dur_sel = 17'(cfg.slot_ticks);
            default:     dur_sel = 17'd0;
        endcase
    end

    assign tick_inc = tick_reg + 17'd1;
    assign hit      = (tick_inc >= dur_sel);
    assign rd_shift = (tick_reg == 17'd0) ? {line_in, shift_reg[7:1]} : shift_reg;

    // next state for one tick
    always_comb
    begin
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        bit_next      = bit_reg;
        step_next     = step_reg;
        shift_next    = shift_reg;
        reading_next  = reading_reg;
        presence_next = presence_reg;
        low_byte_next = low_byte_reg;
        begin_step    = 1'b0;
        begin_idx     = step_reg;
        drive         = 1'b0;
        busy          = 1'b1;
        done          = 1'b0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                busy = 1'b0;
                if (start_req)
                begin
                    presence_next = 1'b0;
                    step_next     = STEP_SKIP_A;
                    tick_next     = 17'd0;
                    phase_next    = PH_RST_HIGH;
                end
            end
            PH_RST_HIGH:
            begin
                tick_next = hit ? 17'd0 : tick_inc;
                if (hit)
                    phase_next = PH_RST_LOW;
            end
            PH_RST_LOW:
            begin
                drive     = 1'b1;
                tick_next = hit ? 17'd0 : tick_inc;
                if (hit)
                    phase_next = PH_PRESENCE;
            end
            PH_PRESENCE:
            begin
                if (!line_in)
                begin
                    tick_next  = 17'd0;
                    phase_next = PH_RECOVERY;
                end
                else if (tick_reg >= cfg.presence_timeout_ticks)
                begin
                    presence_next = 1'b1;
                    tick_next     = 17'd0;
                    phase_next    = PH_RECOVERY;
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            PH_RECOVERY:
            begin
                tick_next  = hit ? 17'd0 : tick_inc;
                begin_step = hit;
            end
            PH_WR_LOW:
            begin
                drive     = 1'b1;
                tick_next = hit ? 17'd0 : tick_inc;
                if (hit)
                    phase_next = PH_WR_HIGH;
            end
            PH_WR_HIGH:
            begin
                tick_next = hit ? 17'd0 : tick_inc;
                if (hit)
                begin
                    shift_next = {1'b0, shift_reg[7:1]};
                    if (bit_reg == LAST_BIT)
                    begin
                        step_next  = step_reg + 3'd1;
                        begin_idx  = step_reg + 3'd1;
                        begin_step = 1'b1;
                    end
                    else
                    begin
                        bit_next   = bit_reg + 3'd1;
                        phase_next = PH_WR_LOW;
                    end
                end
            end
            PH_RD_PRE:
            begin
                tick_next = hit ? 17'd0 : tick_inc;
                if (hit)
                    phase_next = PH_RD_LOW;
            end
            PH_RD_LOW:
            begin
                drive      = 1'b1;
                tick_next  = 17'd0;
                phase_next = PH_RD_GAP;
            end
            PH_RD_GAP:
            begin
                tick_next  = 17'd0;
                phase_next = PH_RD_WAIT;
            end
            PH_RD_WAIT:
            begin
                shift_next = rd_shift;
                tick_next  = hit ? 17'd0 : tick_inc;
                if (hit)
                begin
                    if (bit_reg == LAST_BIT)
                    begin
                        if (step_reg == STEP_RD_LOW)
                        begin
                            low_byte_next = rd_shift;
                            step_next     = STEP_RD_HIGH;
                            begin_idx     = STEP_RD_HIGH;
                            begin_step    = 1'b1;
                        end
                        else
                        begin
                            reading_next = {rd_shift, low_byte_reg};
                            done         = 1'b1;
                            step_next    = STEP_SKIP_A;
                            bit_next     = 3'd0;
                            phase_next   = PH_IDLE;
                        end
                    end
                    else
                    begin
                        bit_next   = bit_reg + 3'd1;
                        phase_next = PH_RD_LOW;
                    end
                end
            end
            default:
            begin
                busy       = 1'b0;
                tick_next  = 17'd0;
                phase_next = PH_IDLE;
            end
        endcase

        // start the next step of the sequence
        if (begin_step)
        begin
            tick_next = 17'd0;
            bit_next  = 3'd0;
            unique case (begin_idx)
                STEP_SKIP_A, STEP_SKIP_B:
                begin
                    shift_next = CMD_SKIP_ROM;
                    phase_next = PH_WR_LOW;
                end
                STEP_CONVERT:
                begin
                    shift_next = CMD_CONVERT;
                    phase_next = PH_WR_LOW;
                end
                STEP_READ_CMD:
                begin
                    shift_next = CMD_READ_SCR;
                    phase_next = PH_WR_LOW;
                end
                STEP_RESET_B:
                begin
                    step_next  = STEP_SKIP_B;
                    phase_next = PH_RST_HIGH;
                end
                STEP_RD_LOW, STEP_RD_HIGH:
                begin
                    shift_next = 8'd0;
                    phase_next = PH_RD_PRE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // result of this tick
    assign res.drive_low        = drive;
    assign res.busy_res         = busy;
    assign res.done_res         = done;
    assign res.raw_reading      = reading_next;
    assign res.presence_missing = presence_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            tick_reg     <= 17'd0;
            bit_reg      <= 3'd0;
            step_reg     <= 3'd0;
            shift_reg    <= 8'd0;
            reading_reg  <= 16'd0;
            presence_reg <= 1'b0;
            low_byte_reg <= 8'd0;
        end
        else if (tick_en)
        begin
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            bit_reg      <= bit_next;
            step_reg     <= step_next;
            shift_reg    <= shift_next;
            reading_reg  <= reading_next;
            presence_reg <= presence_next;
            low_byte_reg <= low_byte_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/onewire_temp_sensor_reader_unit.sv
// channel   dir  signals                          contents
// s_*       in   s_tvalid s_tready s_tdata[7:0]   one 1 us tick: start_req, line_in
// m_*       out  m_tvalid m_tready m_tdata[23:0]  that tick's bus drive and status
// cfg_*     in   cfg_valid cfg_ready cfg_index    timing register writes
//
// one tick per cycle unless m_tready stalls: the sequencer state and the result
// register update in the same cycle a tick is taken; the result shows next cycle
// s_tready is high whenever the result register is empty or being drained
// a stall on m_tready holds the result and the sequencer state
// reset (rst_n low) returns to idle with the timing registers at defaults
//
// top level of the single-wire temperature reader
// depends on owtr_pkg, owtr_cfg_regs, owtr_seq
`timescale 1ns / 1ps
`default_nettype none

module onewire_temp_sensor_reader_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [0] start_req, [1] line_in, [7:2] zero
    input  wire logic [owtr_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [0] drive_low, [1] busy_res, [2] done_res, [18:3] raw_reading,
    // [19] presence_missing, [23:20] zero
    output logic [owtr_pkg::M_TDATA_W-1:0]       m_tdata,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [owtr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [owtr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import owtr_pkg::*;

    owtr_cfg_t cfg;
    owtr_res_t res;
    logic      take;
    logic      m_valid_reg, m_valid_next;
    owtr_res_t m_data_reg;

    owtr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    owtr_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick_en   (take),
        .start_req (s_tdata[0]),
        .line_in   (s_tdata[1]),
        .cfg       (cfg),
        .res       (res)
    );

    // input transfer when the result register can take the new result
    assign s_tready = !m_valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (take)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        if (take)
            m_data_reg <= res;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-RES_W){1'b0}}, m_data_reg};

`ifndef NO_ASSERTIONS
    // done only at the final tick of a running sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && m_data_reg.done_res |-> m_data_reg.busy_res)
        else $error("done without busy");

    // the bus is pulled low only during a sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && m_data_reg.drive_low |-> m_data_reg.busy_res)
        else $error("drive low while idle");

    // s_tready is always high while the result register is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_valid_reg |-> s_tready)
        else $error("stalled with empty result register");

    // a tick transfer always leaves a result to deliver
    assert property (@(posedge clk) disable iff (!rst_n)
        take |=> m_valid_reg)
        else $error("result lost after tick transfer");
`endif

endmodule

`default_nettype wire
